@@ rtl/core/pgs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared types, codes and arithmetic helpers of the PGS segment deframer.
// ----------------------------------------------------------------------------
package pgs_pkg;

    // Result kinds, also used as command kinds in the front-to-back queue.
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_PAY  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_TRUNC = 2'd0;
    localparam logic [1:0] ERR_MAGIC = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    localparam logic [15:0] SUP_MAGIC   = 16'h5047;
    localparam logic [31:0] HALF_RANGE  = 32'h8000_0000;
    localparam logic [3:0]  HDR_LAST    = 4'd12;
    localparam int          QUEUE_DEPTH = 4;
    localparam logic [62:0] NS_MAX      = {63{1'b1}};

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] pts_t;
        logic [63:0] dts_t;
        logic        dts_present;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic        last_of_packet;
        logic [1:0]  err_code;
        logic [31:0] err_offset;
    } t_cmd;

    // Epoch after seeing a new 32-bit timestamp: one step up on a backward jump
    // of more than half the range.
    function automatic logic [31:0] f_unwrap_epoch(input logic [31:0] epoch,
                                                    input logic [31:0] prev,
                                                    input logic        seen,
                                                    input logic [31:0] v);
        logic [31:0] diff;
        diff = prev - v;
        if (seen && (v < prev) && (diff > HALF_RANGE)) begin
            return epoch + 32'd1;
        end
        return epoch;
    endfunction

    // floor((200000 * b + 9) / 18) for a remainder b of the division by nine.
    function automatic logic [16:0] f_frac(input logic [3:0] b);
        logic [16:0] v;
        case (b)
            4'd1:    v = 17'd11111;
            4'd2:    v = 17'd22222;
            4'd3:    v = 17'd33333;
            4'd4:    v = 17'd44444;
            4'd5:    v = 17'd55556;
            4'd6:    v = 17'd66667;
            4'd7:    v = 17'd77778;
            4'd8:    v = 17'd88889;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/pgs_sup_segment_deframer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pgs_sup_segment_deframer
// Splits a PGS subtitle byte stream into header and payload words.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid / o_ready) carries one word per stream byte
// with i_func low, and an end-of-data word with i_func high. The output channel
// (o_valid / i_ready) carries result words: a header word with the unwrapped,
// saturated PTS and DTS in nanoseconds, then every payload byte starting at the
// segment type, plus error and stream-finished words.
// The front frames headers and tracks offsets and timestamp epochs per byte and
// pushes commands into a four-entry queue; o_ready is simply "queue not full".
// The back pops one command per cycle for payload, error and finish words while
// it is idle and the output register is free, so payload bytes stream at one
// word per cycle through the queue and then the output register. A header runs
// two tick-to-nanosecond converters in parallel (a byte-serial division by
// nine), then emits four words; the queue absorbs payload bytes meanwhile.
// Reset clears all control state and empties the queue; an end-of-data word
// also returns the framing state to its reset value. When the receiver stalls,
// the output register holds, then the queue fills and o_ready drops.
// ----------------------------------------------------------------------------
module pgs_sup_segment_deframer #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [62:0]      o_pts_ns,
    output logic [62:0]      o_dts_ns,
    output logic             o_dts_present,
    output logic [7:0]       o_payload_byte,
    output logic             o_last_of_packet,
    output logic             o_last_of_run,
    output logic [1:0]       o_error_code,
    output logic [31:0]      o_error_offset
);
    import pgs_pkg::*;

    logic q_full, q_valid, q_pop, push, accept;
    t_cmd push_cmd, q_cmd;

    // The front takes a word whenever the queue has room.
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    pgs_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_func    (i_func),
        .i_in_byte (i_in_byte),
        .o_cmd     (push_cmd),
        .o_push    (push)
    );

    pgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    pgs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_pts_ns         (o_pts_ns),
        .o_dts_ns         (o_dts_ns),
        .o_dts_present    (o_dts_present),
        .o_payload_byte   (o_payload_byte),
        .o_last_of_packet (o_last_of_packet),
        .o_last_of_run    (o_last_of_run),
        .o_error_code     (o_error_code),
        .o_error_offset   (o_error_offset)
    );

`ifndef SYNTHESIS
    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full))
        else $error("command pushed into full queue");

    // Error and finish words always close their input word's run.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_kind == KIND_ERR) || (o_kind == KIND_DONE))) |-> o_last_of_run)
        else $error("error or finish word without last_of_run");

    // A header word is always followed by a payload word.
    a_hdr_then_pay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && (o_kind == KIND_HDR)) |=> (!o_valid || (o_kind == KIND_PAY)))
        else $error("header word not followed by payload");
`endif

endmodule
`default_nettype wire

@@ rtl/core/pgs_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pgs_front
// Frames headers, tracks offsets and timestamps, and issues commands.
// ----------------------------------------------------------------------------
module pgs_front #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_func,
    input  wire logic [7:0]    i_in_byte,
    output pgs_pkg::t_cmd      o_cmd,
    output logic               o_push
);
    import pgs_pkg::*;

    logic [3:0]             r_phase,     n_phase;
    logic [OFFSET_BITS-1:0] r_offset,    n_offset;
    logic [OFFSET_BITS-1:0] r_start,     n_start;
    logic [15:0]            r_left,      n_left;
    logic [31:0]            r_pts_epoch, n_pts_epoch;
    logic [31:0]            r_pts_prev,  n_pts_prev;
    logic                   r_pts_seen,  n_pts_seen;
    logic [31:0]            r_dts_epoch, n_dts_epoch;
    logic [31:0]            r_dts_prev,  n_dts_prev;
    logic                   r_dts_seen,  n_dts_seen;
    logic                   r_any,       n_any;
    logic                   r_hold,      n_hold;
    logic [7:0]             r_hdr [12];

    logic                   hdr_wr;
    logic [31:0]            pts, dts, pts_ep, dts_ep;
    logic                   dp;
    logic [OFFSET_BITS+31:0] start_ext;
    logic [31:0]            start32;

    assign start_ext = {32'd0, r_start};
    assign start32   = start_ext[31:0];
    assign pts       = {r_hdr[2], r_hdr[3], r_hdr[4], r_hdr[5]};
    assign dts       = {r_hdr[6], r_hdr[7], r_hdr[8], r_hdr[9]};
    assign pts_ep    = f_unwrap_epoch(r_pts_epoch, r_pts_prev, r_pts_seen, pts);
    assign dts_ep    = f_unwrap_epoch(r_dts_epoch, r_dts_prev, r_dts_seen, dts);
    assign dp        = (dts != 32'd0) || (pts == 32'd0);

    always_comb begin
        n_phase     = r_phase;
        n_offset    = r_offset;
        n_start     = r_start;
        n_left      = r_left;
        n_pts_epoch = r_pts_epoch;
        n_pts_prev  = r_pts_prev;
        n_pts_seen  = r_pts_seen;
        n_dts_epoch = r_dts_epoch;
        n_dts_prev  = r_dts_prev;
        n_dts_seen  = r_dts_seen;
        n_any       = r_any;
        n_hold      = r_hold;
        hdr_wr      = 1'b0;
        o_push      = 1'b0;
        o_cmd       = '0;
        if (i_accept) begin
            if (i_func) begin
                if (!r_hold) begin
                    o_push = 1'b1;
                    if ((r_phase != 4'd0) || (r_left != 16'd0)) begin
                        o_cmd.kind       = KIND_ERR;
                        o_cmd.err_code   = ERR_TRUNC;
                        o_cmd.err_offset = start32;
                    end else if (!r_any) begin
                        o_cmd.kind     = KIND_ERR;
                        o_cmd.err_code = ERR_EMPTY;
                    end else begin
                        o_cmd.kind = KIND_DONE;
                    end
                end
                n_phase     = '0;
                n_offset    = '0;
                n_start     = '0;
                n_left      = '0;
                n_pts_epoch = '0;
                n_pts_prev  = '0;
                n_pts_seen  = 1'b0;
                n_dts_epoch = '0;
                n_dts_prev  = '0;
                n_dts_seen  = 1'b0;
                n_any       = 1'b0;
                n_hold      = 1'b0;
            end else if (!r_hold) begin
                n_offset = r_offset + 1'b1;
                if ((r_phase == 4'd0) && (r_left != 16'd0)) begin
                    n_left               = r_left - 16'd1;
                    o_push               = 1'b1;
                    o_cmd.kind           = KIND_PAY;
                    o_cmd.byte0          = i_in_byte;
                    o_cmd.last_of_packet = (r_left == 16'd1);
                end else begin
                    if (r_phase == 4'd0) begin
                        n_start = r_offset;
                    end
                    if (r_phase != HDR_LAST) begin
                        hdr_wr  = 1'b1;
                        n_phase = r_phase + 4'd1;
                    end else begin
                        n_phase = '0;
                        o_push  = 1'b1;
                        if ({r_hdr[0], r_hdr[1]} != SUP_MAGIC) begin
                            n_hold           = 1'b1;
                            o_cmd.kind       = KIND_ERR;
                            o_cmd.err_code   = ERR_MAGIC;
                            o_cmd.err_offset = start32;
                        end else begin
                            n_pts_epoch       = pts_ep;
                            n_pts_prev        = pts;
                            n_pts_seen        = 1'b1;
                            if (dp) begin
                                n_dts_epoch = dts_ep;
                                n_dts_prev  = dts;
                                n_dts_seen  = 1'b1;
                            end
                            n_left            = {r_hdr[11], i_in_byte};
                            n_any             = 1'b1;
                            o_cmd.kind        = KIND_HDR;
                            o_cmd.pts_t       = {pts_ep, pts};
                            o_cmd.dts_t       = {dts_ep, dts};
                            o_cmd.dts_present = dp;
                            o_cmd.byte0       = r_hdr[10];
                            o_cmd.byte1       = r_hdr[11];
                            o_cmd.byte2       = i_in_byte;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_offset    <= '0;
            r_start     <= '0;
            r_left      <= '0;
            r_pts_epoch <= '0;
            r_pts_prev  <= '0;
            r_pts_seen  <= 1'b0;
            r_dts_epoch <= '0;
            r_dts_prev  <= '0;
            r_dts_seen  <= 1'b0;
            r_any       <= 1'b0;
            r_hold      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_start     <= n_start;
            r_left      <= n_left;
            r_pts_epoch <= n_pts_epoch;
            r_pts_prev  <= n_pts_prev;
            r_pts_seen  <= n_pts_seen;
            r_dts_epoch <= n_dts_epoch;
            r_dts_prev  <= n_dts_prev;
            r_dts_seen  <= n_dts_seen;
            r_any       <= n_any;
            r_hold      <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_wr) begin
            r_hdr[r_phase] <= i_in_byte;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/pgs_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pgs_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module pgs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  pgs_pkg::t_cmd      i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output pgs_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);
    import pgs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/pgs_ts2ns.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pgs_ts2ns
// Converts 90 kHz ticks to rounded, saturated nanoseconds.
// ----------------------------------------------------------------------------
module pgs_ts2ns (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_ticks,
    output logic             o_done,
    output logic [62:0]      o_ns
);
    import pgs_pkg::*;

    // ns = floor((200000 * t + 9) / 18). With t = 9 * a + b this is
    // 100000 * a + f_frac(b); a is found one byte per cycle.
    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [63:0] r_num, r_quo;
    logic [3:0]  r_rem;
    logic [48:0] r_plo, r_phi;
    logic [16:0] r_c;
    logic [80:0] r_sum;
    logic [62:0] r_ns;
    logic        r_done;

    logic [11:0] x;
    logic [23:0] prod;
    logic [8:0]  q0;
    logic [11:0] rr;
    logic [80:0] sum;

    assign x    = {r_rem, r_num[63:56]};
    assign prod = x * 12'd3641;
    assign q0   = prod[23:15];
    assign rr   = x - (12'(q0) * 12'd9);
    assign sum  = 81'(r_plo) + (81'(r_phi) << 32) + 81'(r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 4'd10);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd10) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_ticks;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            if (r_cnt < 4'd8) begin
                r_num <= {r_num[55:0], 8'd0};
                r_quo <= {r_quo[55:0], q0[7:0]};
                r_rem <= rr[3:0];
            end else if (r_cnt == 4'd8) begin
                r_plo <= 49'(r_quo[31:0] * 49'd100000);
                r_phi <= 49'(r_quo[63:32] * 49'd100000);
                r_c   <= f_frac(r_rem);
            end else if (r_cnt == 4'd9) begin
                r_sum <= sum;
            end else begin
                r_ns <= (r_sum > 81'(NS_MAX)) ? NS_MAX : r_sum[62:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_ns   = r_ns;

endmodule
`default_nettype wire

@@ rtl/core/pgs_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pgs_back
// Executes queued commands and drives the registered result channel.
// ----------------------------------------------------------------------------
module pgs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  pgs_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [1:0]         o_kind,
    output logic [62:0]        o_pts_ns,
    output logic [62:0]        o_dts_ns,
    output logic               o_dts_present,
    output logic [7:0]         o_payload_byte,
    output logic               o_last_of_packet,
    output logic               o_last_of_run,
    output logic [1:0]         o_error_code,
    output logic [31:0]        o_error_offset
);
    import pgs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  r_sub;
    logic        r_ovalid;
    t_cmd        r_cmd;
    logic [62:0] r_pns, r_dns;

    logic        slot_free, start, pts_done, dts_done, set_valid;
    logic [62:0] pts_ns, dts_ns;

    assign slot_free = !r_ovalid || i_ready;
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid && slot_free;
    assign start     = o_q_pop && (i_q_cmd.kind == KIND_HDR);
    // A new word enters the output register on a direct pop or an emit step.
    assign set_valid = (o_q_pop && (i_q_cmd.kind != KIND_HDR)) ||
                       ((r_state == S_EMIT) && slot_free);

    pgs_ts2ns u_pts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_ticks (i_q_cmd.pts_t),
        .o_done  (pts_done),
        .o_ns    (pts_ns)
    );

    pgs_ts2ns u_dts (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_ticks (i_q_cmd.dts_t),
        .o_done  (dts_done),
        .o_ns    (dts_ns)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sub    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (set_valid) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop && (i_q_cmd.kind == KIND_HDR)) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (pts_done && dts_done) begin
                        r_state <= S_EMIT;
                        r_sub   <= '0;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_sub <= r_sub + 2'd1;
                        if (r_sub == 2'd3) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd <= i_q_cmd;
        end
        if ((r_state == S_CONV) && pts_done) begin
            r_pns <= pts_ns;
            r_dns <= r_cmd.dts_present ? dts_ns : '0;
        end
        if (o_q_pop && (i_q_cmd.kind != KIND_HDR)) begin
            o_kind           <= i_q_cmd.kind;
            o_pts_ns         <= '0;
            o_dts_ns         <= '0;
            o_dts_present    <= 1'b0;
            o_payload_byte   <= i_q_cmd.byte0;
            o_last_of_packet <= i_q_cmd.last_of_packet;
            o_last_of_run    <= 1'b1;
            o_error_code     <= i_q_cmd.err_code;
            o_error_offset   <= i_q_cmd.err_offset;
        end else if ((r_state == S_EMIT) && slot_free) begin
            o_error_code     <= ERR_TRUNC;
            o_error_offset   <= '0;
            if (r_sub == 2'd0) begin
                o_kind           <= KIND_HDR;
                o_pts_ns         <= r_pns;
                o_dts_ns         <= r_dns;
                o_dts_present    <= r_cmd.dts_present;
                o_payload_byte   <= '0;
                o_last_of_packet <= 1'b0;
                o_last_of_run    <= 1'b0;
            end else begin
                o_kind        <= KIND_PAY;
                o_pts_ns      <= '0;
                o_dts_ns      <= '0;
                o_dts_present <= 1'b0;
                case (r_sub)
                    2'd1:    o_payload_byte <= r_cmd.byte0;
                    2'd2:    o_payload_byte <= r_cmd.byte1;
                    default: o_payload_byte <= r_cmd.byte2;
                endcase
                o_last_of_packet <= (r_sub == 2'd3) && ({r_cmd.byte1, r_cmd.byte2} == 16'd0);
                o_last_of_run    <= (r_sub == 2'd3);
            end
        end
    end

    assign o_valid = r_ovalid;

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PGS segment deframer.
// ----------------------------------------------------------------------------
// A short table of hand-made streams runs first: an empty stream, a header
// with extreme timestamps, a bad magic and a cut header. Random streams follow,
// most of them well formed with random timestamps and sizes, some of them cut
// short, corrupted or holding only noise. Every accepted word is run through
// a model of the block kept here. The resulting words are queued, and every
// word that the block delivers is compared with the oldest one in the queue.
// Both sides idle at random in the first two phases; the third runs at full rate.
// ----------------------------------------------------------------------------
module testbench;
    import pgs_pkg::*;

    localparam int      CYCLE_LIMIT = 400000;
    localparam longint unsigned NS_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    // One result word as the block should deliver it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [62:0] pts_ns;
        logic [62:0] dts_ns;
        logic        dts_present;
        logic [7:0]  payload_byte;
        logic        last_of_packet;
        logic        last_of_run;
        logic [1:0]  error_code;
        logic [31:0] error_offset;
    } result_t;

    // One row of the directed table. Where check is set, the first word that
    // this input causes must have the given kind and error code.
    typedef struct packed {
        logic       func;
        logic [7:0] data;
        logic       check;
        logic [1:0] kind;
        logic [1:0] code;
    } stim_row_t;

    localparam int DIR_ROWS = 33;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        // End of data on a fresh stream: nothing framed yet.
        '{1'b1, 8'h00, 1'b1, KIND_ERR, ERR_EMPTY},
        // Header with the largest PTS, a zero DTS and an empty segment.
        '{1'b0, 8'h50, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h47, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'hFF, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'hFF, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'hFF, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'hFF, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h80, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b1, KIND_HDR, ERR_TRUNC},
        '{1'b1, 8'h00, 1'b1, KIND_DONE, ERR_TRUNC},
        // Wrong magic; the byte after it is ignored, and so is end of data.
        '{1'b0, 8'h51, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h47, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h12, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h34, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h56, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h78, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h01, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h15, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h02, 1'b1, KIND_ERR, ERR_MAGIC},
        '{1'b0, 8'hAA, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b1, 8'h00, 1'b0, KIND_HDR, ERR_TRUNC},
        // A header cut after two bytes.
        '{1'b0, 8'h50, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b0, 8'h47, 1'b0, KIND_HDR, ERR_TRUNC},
        '{1'b1, 8'h00, 1'b1, KIND_ERR, ERR_TRUNC}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [62:0] o_pts_ns;
    logic [62:0] o_dts_ns;
    logic        o_dts_present;
    logic [7:0]  o_payload_byte;
    logic        o_last_of_packet;
    logic        o_last_of_run;
    logic [1:0]  o_error_code;
    logic [31:0] o_error_offset;

    always #5 i_clk = ~i_clk;

    pgs_sup_segment_deframer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_in_byte        (i_in_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_pts_ns         (o_pts_ns),
        .o_dts_ns         (o_dts_ns),
        .o_dts_present    (o_dts_present),
        .o_payload_byte   (o_payload_byte),
        .o_last_of_packet (o_last_of_packet),
        .o_last_of_run    (o_last_of_run),
        .o_error_code     (o_error_code),
        .o_error_offset   (o_error_offset)
    );

    result_t pending_words[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      sent_words = 0;
    int      headers_seen = 0;
    int      payload_seen = 0;
    int      errors_seen = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    // Framing state of the model.
    logic [3:0]  hdr_phase;
    logic [7:0]  hdr_buf [13];
    logic [31:0] byte_offset;
    logic [31:0] pkt_start;
    logic [15:0] bytes_left;
    logic [31:0] pts_epoch, pts_last, dts_epoch, dts_last;
    logic        pts_valid, dts_valid, got_packet, halted;

    function automatic void clear_stream();
        hdr_phase   = '0;
        byte_offset = '0;
        pkt_start   = '0;
        bytes_left  = '0;
        pts_epoch   = '0;
        pts_last    = '0;
        pts_valid   = 1'b0;
        dts_epoch   = '0;
        dts_last    = '0;
        dts_valid   = 1'b0;
        got_packet  = 1'b0;
        halted      = 1'b0;
    endfunction

    // 90 kHz ticks to rounded nanoseconds, saturating at the signed maximum.
    function automatic logic [62:0] ticks_to_nanos(input longint unsigned ticks);
        longint unsigned secs, rest, whole, part;
        secs = ticks / 90000;
        rest = ticks % 90000;
        if (secs > NS_TOP / 1000000000) return NS_TOP[62:0];
        whole = secs * 1000000000;
        part  = (rest * 1000000000 + 45000) / 90000;
        if (part > NS_TOP - whole) return NS_TOP[62:0];
        return 63'(whole + part);
    endfunction

    function automatic result_t blank_word(input logic [1:0] kind);
        result_t w;
        w = '0;
        w.kind = kind;
        return w;
    endfunction

    // Applies one accepted word to the model and queues what it must produce.
    function automatic void predict_words(input logic func, input logic [7:0] data);
        result_t w;
        logic [31:0] pts, dts;
        if (func) begin
            if (!halted) begin
                if (hdr_phase != 0 || bytes_left != 0) begin
                    w = blank_word(KIND_ERR);
                    w.error_code   = ERR_TRUNC;
                    w.error_offset = pkt_start;
                end else if (!got_packet) begin
                    w = blank_word(KIND_ERR);
                    w.error_code = ERR_EMPTY;
                end else begin
                    w = blank_word(KIND_DONE);
                end
                w.last_of_run = 1'b1;
                pending_words.push_back(w);
            end
            clear_stream();
            return;
        end
        if (halted) return;
        if (hdr_phase == 0 && bytes_left != 0) begin
            bytes_left  = bytes_left - 1;
            byte_offset = byte_offset + 1;
            w = blank_word(KIND_PAY);
            w.payload_byte   = data;
            w.last_of_packet = (bytes_left == 0);
            w.last_of_run    = 1'b1;
            pending_words.push_back(w);
            return;
        end
        if (hdr_phase == 0) pkt_start = byte_offset;
        hdr_buf[hdr_phase] = data;
        byte_offset = byte_offset + 1;
        if (hdr_phase != HDR_LAST) begin
            hdr_phase = hdr_phase + 1;
            return;
        end
        hdr_phase = '0;
        if ({hdr_buf[0], hdr_buf[1]} != SUP_MAGIC) begin
            halted = 1'b1;
            w = blank_word(KIND_ERR);
            w.error_code   = ERR_MAGIC;
            w.error_offset = pkt_start;
            w.last_of_run  = 1'b1;
            pending_words.push_back(w);
            return;
        end
        pts = {hdr_buf[2], hdr_buf[3], hdr_buf[4], hdr_buf[5]};
        dts = {hdr_buf[6], hdr_buf[7], hdr_buf[8], hdr_buf[9]};
        w = blank_word(KIND_HDR);
        // A timestamp that falls back by more than half the range has wrapped.
        if (pts_valid && pts < pts_last && (pts_last - pts) > HALF_RANGE)
            pts_epoch = pts_epoch + 1;
        pts_last  = pts;
        pts_valid = 1'b1;
        w.pts_ns  = ticks_to_nanos({pts_epoch, pts});
        if (dts != 0 || pts == 0) begin
            if (dts_valid && dts < dts_last && (dts_last - dts) > HALF_RANGE)
                dts_epoch = dts_epoch + 1;
            dts_last      = dts;
            dts_valid     = 1'b1;
            w.dts_ns      = ticks_to_nanos({dts_epoch, dts});
            w.dts_present = 1'b1;
        end
        bytes_left = {hdr_buf[11], hdr_buf[12]};
        got_packet = 1'b1;
        pending_words.push_back(w);
        for (int i = 10; i < 13; i++) begin
            w = blank_word(KIND_PAY);
            w.payload_byte = hdr_buf[i];
            if (i == 12) begin
                w.last_of_packet = (bytes_left == 0);
                w.last_of_run    = 1'b1;
            end
            pending_words.push_back(w);
        end
    endfunction

    // Offers one word, waits for it to be taken, then runs the model on it.
    // Each cycle ahead of the word is idle with the sender's idle percentage.
    task automatic send_word(input logic func, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= func;
        i_in_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        sent_words++;
        predict_words(func, data);
    endtask

    task automatic send_header(input logic [15:0] magic, input logic [31:0] pts,
                               input logic [31:0] dts, input logic [7:0] seg_type,
                               input logic [15:0] size, input int cut_at);
        logic [7:0] hdr [13];
        hdr = '{magic[15:8], magic[7:0], pts[31:24], pts[23:16], pts[15:8], pts[7:0],
                dts[31:24], dts[23:16], dts[15:8], dts[7:0], seg_type,
                size[15:8], size[7:0]};
        for (int i = 0; i < 13 && i < cut_at; i++) send_word(1'b0, hdr[i]);
    endtask

    function automatic logic [31:0] pick_stamp(input logic [31:0] prev);
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FF00 + $urandom_range(255);
            2:       return $urandom_range(1000);
            3:       return prev + $urandom_range(90000);
            default: return $urandom;
        endcase
    endfunction

    // Random streams until about the given number of words have gone in.
    task automatic send_random_streams(input int goal);
        int         start, npkt, size, cut;
        logic [31:0] pts, dts;
        logic [15:0] magic;
        start = sent_words;
        pts = '0;
        while (sent_words - start < goal) begin
            if ($urandom_range(19) == 0) begin
                // Noise ahead of the stream throws the framing off.
                repeat ($urandom_range(1, 3)) send_word(1'b0, 8'($urandom));
            end
            npkt = $urandom_range(0, 4);
            for (int p = 0; p < npkt; p++) begin
                magic = ($urandom_range(15) == 0) ? 16'($urandom) : SUP_MAGIC;
                pts   = pick_stamp(pts);
                dts   = $urandom_range(1) ? 32'd0 : pick_stamp(pts);
                size  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
                // Now and then the stream ends inside a header or a payload.
                cut   = ($urandom_range(11) == 0) ? $urandom_range(1, 12 + size) : 99;
                send_header(magic, pts, dts, 8'($urandom), 16'(size), cut);
                for (int b = 13; b < 13 + size && b < cut; b++)
                    send_word(1'b0, 8'($urandom));
                if (cut != 99) break;
            end
            send_word(1'b1, 8'($urandom));
        end
    endtask

    // Receiver stalls.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Output checker.
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: kind %0d", o_kind);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                case (want.kind)
                    KIND_HDR: headers_seen++;
                    KIND_PAY: payload_seen++;
                    KIND_ERR: errors_seen++;
                    default: ;
                endcase
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    mismatches++;
                end
                if (o_pts_ns !== want.pts_ns) begin
                    $error("pts_ns: expected %0d, got %0d", want.pts_ns, o_pts_ns);
                    mismatches++;
                end
                if (o_dts_ns !== want.dts_ns) begin
                    $error("dts_ns: expected %0d, got %0d", want.dts_ns, o_dts_ns);
                    mismatches++;
                end
                if (o_dts_present !== want.dts_present) begin
                    $error("dts_present: expected %0d, got %0d",
                           want.dts_present, o_dts_present);
                    mismatches++;
                end
                if (o_payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0h, got %0h",
                           want.payload_byte, o_payload_byte);
                    mismatches++;
                end
                if (o_last_of_packet !== want.last_of_packet) begin
                    $error("last_of_packet: expected %0d, got %0d",
                           want.last_of_packet, o_last_of_packet);
                    mismatches++;
                end
                if (o_last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, o_last_of_run);
                    mismatches++;
                end
                if (o_error_code !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, o_error_code);
                    mismatches++;
                end
                if (o_error_offset !== want.error_offset) begin
                    $error("error_offset: expected %0d, got %0d",
                           want.error_offset, o_error_offset);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int      before_cnt;
        result_t first;
        clear_stream();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender idles rarely, receiver stalls most of the time.
        send_idle_pct = 9;
        recv_idle_pct = 74;
        for (int r = 0; r < DIR_ROWS; r++) begin
            before_cnt = pending_words.size();
            send_word(DIR_TABLE[r].func, DIR_TABLE[r].data);
            if (DIR_TABLE[r].check) begin
                if (pending_words.size() == before_cnt) begin
                    $error("table row %0d: no word predicted", r);
                    mismatches++;
                end else begin
                    first = pending_words[before_cnt];
                    if (first.kind !== DIR_TABLE[r].kind ||
                        first.error_code !== DIR_TABLE[r].code) begin
                        $error("table row %0d: model disagrees with the table", r);
                        mismatches++;
                    end
                end
            end
        end
        send_random_streams(75);

        // Phase two: the other way round.
        send_idle_pct = 74;
        recv_idle_pct = 9;
        send_random_streams(80);

        // Phase three: full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_streams(80);
        i_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d input words; checked %0d headers, %0d payload bytes, %0d errors.",
                 sent_words, headers_seen, payload_seen, errors_seen);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pgs_pkg.sv
rtl/core/pgs_front.sv
rtl/core/pgs_queue.sv
rtl/core/pgs_ts2ns.sv
rtl/core/pgs_back.sv
rtl/core/pgs_sup_segment_deframer.sv
bench/testbench.sv
